// ----- src/xtea_block_cipher_assert.svh -----
`ifndef XTEA_BLOCK_CIPHER_ASSERT_SVH
`define XTEA_BLOCK_CIPHER_ASSERT_SVH

// clocked assertion, quiet while reset is held
`define XTEA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds through reset
`define XTEA_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/xtea_pkg.sv -----
package xtea_pkg;

  localparam logic [31:0] XT_DELTA = 32'h9e3779b9;

  // one block in flight, keys travel with it
  typedef struct packed {
    logic             func;
    logic [31:0]      v0;
    logic [31:0]      v1;
    logic [3:0][31:0] key;
  } xtea_item_t;

  localparam logic FUNC_ENC = 1'b0;
  localparam logic FUNC_DEC = 1'b1;

  function automatic logic [31:0] xt_mix(input logic [31:0] v);
    return ((v << 4) ^ (v >> 5)) + v;
  endfunction

  // running sum after n additions of delta, modulo 2^32
  function automatic logic [31:0] sum_at(input int n);
    logic [31:0] nn;
    nn = 32'(n);
    return 32'(XT_DELTA * nn);
  endfunction

endpackage

// ----- src/xtea_in_if.sv -----
interface xtea_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] block_left;
  logic [31:0] block_right;
  logic [31:0] key_word_0;
  logic [31:0] key_word_1;
  logic [31:0] key_word_2;
  logic [31:0] key_word_3;

  modport source (
    output valid, func, block_left, block_right,
    output key_word_0, key_word_1, key_word_2, key_word_3,
    input  ready
  );
  modport sink (
    input  valid, func, block_left, block_right,
    input  key_word_0, key_word_1, key_word_2, key_word_3,
    output ready
  );
endinterface

// ----- src/xtea_out_if.sv -----
interface xtea_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_left;
  logic [31:0] out_right;

  modport source (output valid, out_left, out_right, input ready);
  modport sink (input valid, out_left, out_right, output ready);
endinterface

// ----- src/xtea_block_cipher.sv -----
// XTEA block cipher, fully unrolled: one half-round per register stage, so
// 2*ROUNDS stages (64 at the default 32 rounds). A block is taken every cycle
// while the output is not held back, and each result passes through every
// stage in order. The last stage is the output register; while its beat waits
// the whole pipeline holds, and only an empty first stage may still fill. Each
// beat carries its own direction (func 0 encrypts, 1 decrypts) and key, so
// beats of either direction and any key can be mixed freely. No configuration,
// no state beyond the pipeline.
module xtea_block_cipher import xtea_pkg::*; #(
  parameter int ROUNDS = 32
) (
  input  logic  clk,
  input  logic  rst_n,
  xtea_in_if.sink    in_ch,
  xtea_out_if.source out_ch
);

  localparam int DEPTH = 2 * ROUNDS;

  // advance of the whole pipe
  logic       adv;
  logic       load0;
  xtea_item_t head;
  logic       vld   [DEPTH];
  xtea_item_t data  [DEPTH];

  assign adv   = out_ch.ready || !vld[DEPTH-1];
  // first stage may also fill a bubble while the pipe is held
  assign load0 = adv || !vld[0];
  assign in_ch.ready = load0;

  always_comb begin
    head.func   = in_ch.func;
    head.v0     = in_ch.block_left;
    head.v1     = in_ch.block_right;
    head.key[0] = in_ch.key_word_0;
    head.key[1] = in_ch.key_word_1;
    head.key[2] = in_ch.key_word_2;
    head.key[3] = in_ch.key_word_3;
  end

  for (genvar s = 0; s < DEPTH; s++) begin : g_stage
    if (s == 0) begin : g_first
      xtea_hr_stage #(.ROUNDS(ROUNDS), .STAGE(s)) u_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load0),
        .in_valid (in_ch.valid),
        .in_data  (head),
        .valid_r  (vld[s]),
        .data_r   (data[s])
      );
    end else begin : g_rest
      xtea_hr_stage #(.ROUNDS(ROUNDS), .STAGE(s)) u_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (adv),
        .in_valid (vld[s-1]),
        .in_data  (data[s-1]),
        .valid_r  (vld[s]),
        .data_r   (data[s])
      );
    end
  end

  // last stage doubles as the output register
  assign out_ch.valid     = vld[DEPTH-1];
  assign out_ch.out_left  = data[DEPTH-1].v0;
  assign out_ch.out_right = data[DEPTH-1].v1;

endmodule

// ----- src/xtea_hr_stage.sv -----
module xtea_hr_stage import xtea_pkg::*; #(
  parameter int ROUNDS = 32,
  parameter int STAGE  = 0
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  logic       in_valid,
  input  xtea_item_t in_data,
  output logic       valid_r,
  output xtea_item_t data_r
);

  localparam int RND    = STAGE / 2;
  localparam bit SECOND = (STAGE % 2) == 1;
  // sums are fixed per stage, one for each direction
  localparam logic [31:0] SUM_E = sum_at(SECOND ? RND + 1 : RND);
  localparam logic [31:0] SUM_D = sum_at(SECOND ? ROUNDS - RND - 1 : ROUNDS - RND);
  localparam logic [1:0]  IDX_E = SECOND ? SUM_E[12:11] : SUM_E[1:0];
  localparam logic [1:0]  IDX_D = SECOND ? SUM_D[1:0] : SUM_D[12:11];

  logic        upd_v0;
  logic [31:0] src;
  logic [31:0] dst;
  logic [31:0] sum_k;
  logic [31:0] t;
  logic [31:0] res;
  logic        dec;
  logic        valid_nxt;
  xtea_item_t  data_nxt;

  always_comb begin
    dec    = (in_data.func == FUNC_DEC);
    // encrypt touches v0 first then v1, decrypt the other way round
    upd_v0 = SECOND ? dec : !dec;
    src    = upd_v0 ? in_data.v1 : in_data.v0;
    dst    = upd_v0 ? in_data.v0 : in_data.v1;
    sum_k  = (dec ? SUM_D : SUM_E) + in_data.key[dec ? IDX_D : IDX_E];
    t      = xt_mix(src) ^ sum_k;
    res    = dec ? dst - t : dst + t;
    data_nxt = in_data;
    if (upd_v0) begin
      data_nxt.v0 = res;
    end else begin
      data_nxt.v1 = res;
    end
    valid_nxt = in_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ----- src/xtea_chk.sv -----
`include "xtea_block_cipher_assert.svh"

module xtea_chk #(
  parameter int ROUNDS = 32
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_left,
  input logic [31:0] out_right
);

  localparam int DEPTH = 2 * ROUNDS;
  localparam int CW    = $clog2(DEPTH + 2);

  logic          in_beat;
  logic          out_beat;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] cnt_nxt;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  // beats accepted but not yet delivered
  always_comb begin
    cnt_nxt = cnt_r;
    if (in_beat && !out_beat) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (!in_beat && out_beat) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  `XTEA_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_left) && $stable(out_right), "held result changed")
  `XTEA_ASSERT(a_no_invent, out_valid |-> cnt_r != '0, "result without an accepted block")
  `XTEA_ASSERT(a_depth, cnt_r <= CW'(DEPTH), "more blocks in flight than stages")
  `XTEA_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid, "result straight after reset")

endmodule

bind xtea_block_cipher xtea_chk #(.ROUNDS(ROUNDS)) u_xtea_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_left  (out_ch.out_left),
  .out_right (out_ch.out_right)
);

// ----- dv/xtea_block_cipher_tb.sv -----
`timescale 1ns / 1ps

module xtea_block_cipher_tb;
  import xtea_pkg::*;

  localparam int ROUNDS = 32;
  // pipeline depth in stages, one stage per half-round
  localparam int PIPE_DEPTH = 2 * ROUNDS;
  localparam int TARGET_BEATS = 950;
  // worst case is far below this: every beat's source gap and result stall, plus pipeline fill
  localparam int CYCLE_LIMIT = 200000;

  // one processed block as it leaves the cipher
  typedef struct packed {
    logic [31:0] left;
    logic [31:0] right;
  } block_pair_t;

  // a directed row: the beat, and optionally a result typed in by hand
  typedef struct {
    xtea_item_t  blk;
    bit          typed;
    block_pair_t want;
  } stim_row_t;

  logic clk;
  logic rst_n;

  xtea_in_if  in_bus ();
  xtea_out_if out_bus ();

  xtea_block_cipher #(
    .ROUNDS(ROUNDS)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_bus),
    .out_ch(out_bus)
  );

  // processed blocks still owed by the cipher, oldest first
  block_pair_t blocks_due[$];
  stim_row_t   directed_rows[$];

  int errors;
  int beats_sent;
  int cycle_count;
  // remaining beats of a no-idle stretch on each side
  int src_quiet;
  int snk_quiet;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog, a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d blocks still due", cycle_count,
               blocks_due.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  // the xtea round function on one half of the block
  function automatic logic [31:0] feistel_mix(input logic [31:0] w);
    return ((w << 4) ^ (w >> 5)) + w;
  endfunction

  // full xtea pass over one beat, direction taken from the beat itself
  function automatic block_pair_t xtea_cipher(input xtea_item_t it);
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] s;
    block_pair_t res;
    y = it.v0;
    z = it.v1;
    if (it.func == FUNC_ENC) begin
      s = '0;
      for (int r = 0; r < ROUNDS; r++) begin
        y = y + (feistel_mix(z) ^ (s + it.key[s[1:0]]));
        s = s + XT_DELTA;
        z = z + (feistel_mix(y) ^ (s + it.key[s[12:11]]));
      end
    end else begin
      // starting sum wraps modulo 2^32
      s = XT_DELTA * 32'(ROUNDS);
      for (int r = 0; r < ROUNDS; r++) begin
        z = z - (feistel_mix(y) ^ (s + it.key[s[12:11]]));
        s = s - XT_DELTA;
        y = y - (feistel_mix(z) ^ (s + it.key[s[1:0]]));
      end
    end
    res.left  = y;
    res.right = z;
    return res;
  endfunction

  // idle cycles before the next beat, with occasional stretches of none
  function automatic int draw_wait(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      quiet = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 8);
  endfunction

  // words leaning towards the corners: zero, all ones, one-hot
  function automatic logic [31:0] random_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return 32'h1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  function automatic stim_row_t table_row(input logic dir, input logic [31:0] l, r,
                                          input logic [31:0] k0, k1, k2, k3,
                                          input bit typed = 1'b0,
                                          input logic [31:0] wl = '0,
                                          input logic [31:0] wr = '0);
    stim_row_t row;
    row.blk.func   = dir;
    row.blk.v0     = l;
    row.blk.v1     = r;
    row.blk.key[0] = k0;
    row.blk.key[1] = k1;
    row.blk.key[2] = k2;
    row.blk.key[3] = k3;
    row.typed      = typed;
    row.want.left  = wl;
    row.want.right = wr;
    return row;
  endfunction

  // offer one beat, hold it until the cipher takes it, then log what is owed
  task automatic send_block(input xtea_item_t it, input bit typed, input block_pair_t want);
    int gap;
    gap = draw_wait(src_quiet);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.func        <= it.func;
    in_bus.block_left  <= it.v0;
    in_bus.block_right <= it.v1;
    in_bus.key_word_0  <= it.key[0];
    in_bus.key_word_1  <= it.key[1];
    in_bus.key_word_2  <= it.key[2];
    in_bus.key_word_3  <= it.key[3];
    do @(posedge clk); while (!in_bus.ready);
    blocks_due.push_back(typed ? want : xtea_cipher(it));
    beats_sent++;
  endtask

  function automatic xtea_item_t random_block(input logic [3:0][31:0] key);
    xtea_item_t it;
    it.func = $urandom_range(0, 1) ? FUNC_DEC : FUNC_ENC;
    it.v0   = random_word();
    it.v1   = random_word();
    it.key  = key;
    return it;
  endfunction

  // result side: random stall per beat, then compare against the oldest block owed
  initial begin
    int stall;
    block_pair_t want;
    wait (rst_n);
    forever begin
      stall = draw_wait(snk_quiet);
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!out_bus.valid);
      if (blocks_due.size() == 0) begin
        flag_error($sformatf("unexpected beat %08h_%08h", out_bus.out_left,
                             out_bus.out_right));
      end else begin
        want = blocks_due.pop_front();
        if (out_bus.out_left !== want.left)
          flag_error($sformatf("out_left %08h, wanted %08h", out_bus.out_left, want.left));
        if (out_bus.out_right !== want.right)
          flag_error($sformatf("out_right %08h, wanted %08h", out_bus.out_right,
                               want.right));
      end
    end
  end

  // stimulus: directed table first, then random beats and round trips
  initial begin
    xtea_item_t       it;
    xtea_item_t       back;
    logic [3:0][31:0] key;
    block_pair_t      none;

    errors      = 0;
    beats_sent  = 0;
    cycle_count = 0;
    src_quiet   = 0;
    snk_quiet   = 0;
    none        = '0;

    rst_n              = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.func        = FUNC_ENC;
    in_bus.block_left  = '0;
    in_bus.block_right = '0;
    in_bus.key_word_0  = '0;
    in_bus.key_word_1  = '0;
    in_bus.key_word_2  = '0;
    in_bus.key_word_3  = '0;
    out_bus.ready      = 1'b0;

    // all-zero and all-one corners, both directions
    directed_rows.push_back(table_row(FUNC_ENC, '0, '0, '0, '0, '0, '0));
    directed_rows.push_back(table_row(FUNC_DEC, '0, '0, '0, '0, '0, '0));
    directed_rows.push_back(table_row(FUNC_ENC, '1, '1, '1, '1, '1, '1));
    directed_rows.push_back(table_row(FUNC_DEC, '1, '1, '1, '1, '1, '1));
    // published vector and its inverse
    directed_rows.push_back(table_row(FUNC_ENC, 32'h41424344, 32'h45464748,
                                      32'h00010203, 32'h04050607, 32'h08090a0b,
                                      32'h0c0d0e0f, 1'b1, 32'h497df3d0, 32'h72612cb5));
    directed_rows.push_back(table_row(FUNC_DEC, 32'h497df3d0, 32'h72612cb5,
                                      32'h00010203, 32'h04050607, 32'h08090a0b,
                                      32'h0c0d0e0f, 1'b1, 32'h41424344, 32'h45464748));
    // one key word live at a time, so each key slot selection shows up alone
    directed_rows.push_back(table_row(FUNC_ENC, '0, '0, '1, '0, '0, '0));
    directed_rows.push_back(table_row(FUNC_ENC, '0, '0, '0, '1, '0, '0));
    directed_rows.push_back(table_row(FUNC_ENC, '0, '0, '0, '0, '1, '0));
    directed_rows.push_back(table_row(FUNC_ENC, '0, '0, '0, '0, '0, '1));
    directed_rows.push_back(table_row(FUNC_DEC, '1, '1, '1, '0, '0, '0));
    directed_rows.push_back(table_row(FUNC_DEC, '1, '1, '0, '1, '0, '0));
    directed_rows.push_back(table_row(FUNC_DEC, '1, '1, '0, '0, '1, '0));
    directed_rows.push_back(table_row(FUNC_DEC, '1, '1, '0, '0, '0, '1));
    // one half at its maximum, the other at zero; checkerboard keys
    directed_rows.push_back(table_row(FUNC_ENC, '1, '0, 32'haaaaaaaa, 32'haaaaaaaa,
                                      32'haaaaaaaa, 32'haaaaaaaa));
    directed_rows.push_back(table_row(FUNC_DEC, '0, '1, 32'h55555555, 32'h55555555,
                                      32'h55555555, 32'h55555555));
    // top and bottom bits alone, where carries and the sum wrap bite
    directed_rows.push_back(table_row(FUNC_ENC, 32'h80000000, 32'h00000001,
                                      32'h00000001, 32'h80000000, 32'h7fffffff,
                                      32'hfffffffe));
    directed_rows.push_back(table_row(FUNC_DEC, 32'h80000000, 32'h00000001,
                                      32'h00000001, 32'h80000000, 32'h7fffffff,
                                      32'hfffffffe));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_block(directed_rows[i].blk, directed_rows[i].typed, directed_rows[i].want);

    // random part: single beats, and pairs where the second undoes the first
    key = {random_word(), random_word(), random_word(), random_word()};
    while (beats_sent < TARGET_BEATS) begin
      // a quarter of the time the key carries over from the last beat
      if ($urandom_range(0, 3) != 0)
        key = {random_word(), random_word(), random_word(), random_word()};
      it = random_block(key);
      send_block(it, 1'b0, none);
      if ($urandom_range(0, 9) >= 6) begin
        back      = it;
        back.func = (it.func == FUNC_ENC) ? FUNC_DEC : FUNC_ENC;
        {back.v0, back.v1} = xtea_cipher(it);
        send_block(back, 1'b0, none);
      end
    end
    in_bus.valid <= 1'b0;

    // drain the pipeline, then allow a little over its depth for strays
    while (blocks_due.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 16) @(posedge clk);

    if (errors == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
